>>> rtl/core/occupancy_grid_ray_cast_defines.svh
// Assertion macros for the occupancy grid ray caster.
// Used by the top level only; no other dependencies.
`ifndef OCCUPANCY_GRID_RAY_CAST_DEFINES_SVH
`define OCCUPANCY_GRID_RAY_CAST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OGRC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define OGRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ogrc_pkg.sv
// Shared types, constants and the cell address function of the ray caster.
// No dependencies.
`default_nettype none

package ogrc_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MAP_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(MAP_DEPTH);
   localparam int X_W         = $clog2(MAX_WIDTH);
   localparam int Y_W         = $clog2(MAX_HEIGHT);

   localparam int COORD_W     = 13;
   localparam int CFG_W       = 11;
   localparam int DIST_W      = 27;
   localparam int DELTA_W     = 13;
   localparam int ERR_W       = 16;
   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_HEIGHT = CSR_INDEX_W'(1);

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   localparam logic [CFG_W-1:0] MAP_SIZE_RESET = CFG_W'(1024);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [CFG_W-1:0]          cfg_type;
   typedef logic [DIST_W-1:0]         dist_type;
   typedef logic [CSR_INDEX_W-1:0]    csr_index_type;
   typedef logic [ADDR_W-1:0]         addr_type;

   // Row-major address; only meaningful for cells inside the storage.
   function automatic addr_type cell_addr(input coord_type x, input coord_type y);
      addr_type row;
      row = ADDR_W'(y[Y_W-1:0]) * ADDR_W'(MAX_WIDTH);
      return row + ADDR_W'(x[X_W-1:0]);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/occupancy_grid_ray_cast.sv
// Occupancy grid ray caster: one-bit map in a RAM, Bresenham walk over it.
// Sequence: a write goes straight to FINISH, where its result is registered; a cast goes
// through SETUP, then ISSUE (RAM read) and CHECK (test) for each cell, then SQUARE, SUM, FINISH.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset: synchronous; a clearing pass then writes every one of the MAX_WIDTH*MAX_HEIGHT
// cells, during which req_stall stays high; csr writes are taken.
`default_nettype none

`include "occupancy_grid_ray_cast_defines.svh"

module occupancy_grid_ray_cast (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_command,
   input  logic                   req_cell_blocks,
   input  ogrc_pkg::coord_type    req_start_x,
   input  ogrc_pkg::coord_type    req_start_y,
   input  ogrc_pkg::coord_type    req_end_x,
   input  ogrc_pkg::coord_type    req_end_y,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_stopped,
   output ogrc_pkg::coord_type    rsp_stop_x,
   output ogrc_pkg::coord_type    rsp_stop_y,
   output ogrc_pkg::dist_type     rsp_distance_squared,
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  ogrc_pkg::csr_index_type csr_index,
   input  ogrc_pkg::cfg_type      csr_wdata
);

   import ogrc_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_ISSUE,
      ST_CHECK,
      ST_SQUARE,
      ST_SUM,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   addr_type  clr_ff, clr_in;
   cfg_type   map_width_ff, map_width_in;
   cfg_type   map_height_ff, map_height_in;
   logic      rsp_valid_ff, rsp_valid_in;

   coord_type sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   coord_type a_ff, a_in, b_ff, b_in, a1_ff, a1_in;
   logic [DELTA_W-1:0] da_ff, da_in, db_ff, db_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic      steep_ff, steep_in;
   logic      astep_neg_ff, astep_neg_in, bstep_neg_ff, bstep_neg_in;
   logic      oob_ff, oob_in;
   logic      stopped_ff, stopped_in;
   dist_type  sqx_ff, sqx_in, sqy_ff, sqy_in, d2_ff, d2_in;

   logic      rsp_stopped_ff, rsp_stopped_in;
   coord_type rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   dist_type  rsp_d2_ff, rsp_d2_in;

   // datapath helpers
   logic      req_accept;
   logic      wr_in_store;
   coord_type cx, cy;
   logic      cell_in_map;
   logic signed [COORD_W:0] dxs, dys, dx, dy;
   logic [COORD_W:0] adx_full, ady_full;
   logic [DELTA_W-1:0] adx, ady;
   logic signed [2*COORD_W+1:0] dx_sq, dy_sq;
   logic signed [ERR_W-1:0] err_tmp;
   logic signed [ERR_W:0] err_tmp_dbl, err_dbl, da_s;
   logic      hit;

   // RAM port
   logic      ram_we, ram_re;
   addr_type  ram_waddr, ram_raddr;
   logic [0:0] ram_wdata, ram_rdata;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;

   assign wr_in_store = !req_start_x[COORD_W-1] && !req_start_y[COORD_W-1]
                     && ({1'b0, req_start_x[COORD_W-2:0]} < COORD_W'(MAX_WIDTH))
                     && ({1'b0, req_start_y[COORD_W-2:0]} < COORD_W'(MAX_HEIGHT));

   assign cx = steep_ff ? b_ff : a_ff;
   assign cy = steep_ff ? a_ff : b_ff;

   assign cell_in_map = !cx[COORD_W-1] && !cy[COORD_W-1]
                     && ({1'b0, cx[COORD_W-2:0]} < COORD_W'(MAX_WIDTH))
                     && ({1'b0, cy[COORD_W-2:0]} < COORD_W'(MAX_HEIGHT))
                     && ({1'b0, cx[COORD_W-2:0]} < {2'b00, map_width_ff})
                     && ({1'b0, cy[COORD_W-2:0]} < {2'b00, map_height_ff});

   assign dxs      = {ex_ff[COORD_W-1], ex_ff} - {sx_ff[COORD_W-1], sx_ff};
   assign dys      = {ey_ff[COORD_W-1], ey_ff} - {sy_ff[COORD_W-1], sy_ff};
   assign adx_full = dxs[COORD_W] ? $unsigned(-dxs) : $unsigned(dxs);
   assign ady_full = dys[COORD_W] ? $unsigned(-dys) : $unsigned(dys);
   assign adx      = adx_full[DELTA_W-1:0];
   assign ady      = ady_full[DELTA_W-1:0];

   assign dx    = {cx[COORD_W-1], cx} - {sx_ff[COORD_W-1], sx_ff};
   assign dy    = {cy[COORD_W-1], cy} - {sy_ff[COORD_W-1], sy_ff};
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;

   assign err_tmp     = err_ff + $signed(ERR_W'(db_ff));
   assign err_tmp_dbl = {err_tmp, 1'b0};
   assign err_dbl     = {err_ff, 1'b0};
   assign da_s        = $signed((ERR_W + 1)'(da_ff));

   assign hit = oob_ff || ram_rdata[0];

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cell_addr(req_start_x, req_start_y);
      ram_wdata = req_cell_blocks;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = 1'b0;
      end else if (req_accept && req_command == CMD_WRITE && wr_in_store) begin
         ram_we = 1'b1;
      end
   end

   assign ram_re    = (state_ff == ST_ISSUE);
   assign ram_raddr = cell_addr(cx, cy);

   ogrc_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      map_width_in   = map_width_ff;
      map_height_in  = map_height_ff;
      rsp_valid_in   = rsp_valid_ff;
      sx_in          = sx_ff;
      sy_in          = sy_ff;
      ex_in          = ex_ff;
      ey_in          = ey_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      a1_in          = a1_ff;
      da_in          = da_ff;
      db_in          = db_ff;
      err_in         = err_ff;
      steep_in       = steep_ff;
      astep_neg_in   = astep_neg_ff;
      bstep_neg_in   = bstep_neg_ff;
      oob_in         = oob_ff;
      stopped_in     = stopped_ff;
      sqx_in         = sqx_ff;
      sqy_in         = sqy_ff;
      d2_in          = d2_ff;
      rsp_stopped_in = rsp_stopped_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_d2_in      = rsp_d2_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_width_in  = csr_wdata;
            CSR_MAP_HEIGHT: map_height_in = csr_wdata;
            default: ;
         endcase
      end

      // drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               sx_in = req_start_x;
               sy_in = req_start_y;
               ex_in = req_end_x;
               ey_in = req_end_y;
               if (req_command == CMD_CAST) begin
                  state_in = ST_SETUP;
               end else begin
                  // write transaction reports all zeros
                  a_in       = '0;
                  b_in       = '0;
                  stopped_in = 1'b0;
                  d2_in      = '0;
                  state_in   = ST_FINISH;
               end
            end
         end
         ST_SETUP: begin
            steep_in = (ady > adx);
            err_in   = '0;
            if (ady > adx) begin
               a_in         = sy_ff;
               b_in         = sx_ff;
               a1_in        = ey_ff;
               da_in        = ady;
               db_in        = adx;
               astep_neg_in = !(sy_ff < ey_ff);
               bstep_neg_in = !(sx_ff < ex_ff);
            end else begin
               a_in         = sx_ff;
               b_in         = sy_ff;
               a1_in        = ex_ff;
               da_in        = adx;
               db_in        = ady;
               astep_neg_in = !(sx_ff < ex_ff);
               bstep_neg_in = !(sy_ff < ey_ff);
            end
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            oob_in   = !cell_in_map;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (hit || a_ff == a1_ff) begin
               stopped_in = hit;
               state_in   = ST_SQUARE;
            end else begin
               // advance one cell along the major axis
               a_in = a_ff + (astep_neg_ff ? -COORD_W'(1) : COORD_W'(1));
               if (err_tmp_dbl >= da_s) begin
                  b_in   = b_ff + (bstep_neg_ff ? -COORD_W'(1) : COORD_W'(1));
                  err_in = err_tmp - $signed(ERR_W'(da_ff));
               end else begin
                  err_in = err_tmp;
               end
               state_in = ST_ISSUE;
            end
         end
         ST_SQUARE: begin
            sqx_in   = dx_sq[DIST_W-1:0];
            sqy_in   = dy_sq[DIST_W-1:0];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            d2_in    = sqx_ff + sqy_ff;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_stopped_in = stopped_ff;
               rsp_x_in       = cx;
               rsp_y_in       = cy;
               rsp_d2_in      = d2_ff;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         map_width_ff  <= MAP_SIZE_RESET;
         map_height_ff <= MAP_SIZE_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sx_ff          <= sx_in;
      sy_ff          <= sy_in;
      ex_ff          <= ex_in;
      ey_ff          <= ey_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      a1_ff          <= a1_in;
      da_ff          <= da_in;
      db_ff          <= db_in;
      err_ff         <= err_in;
      steep_ff       <= steep_in;
      astep_neg_ff   <= astep_neg_in;
      bstep_neg_ff   <= bstep_neg_in;
      oob_ff         <= oob_in;
      stopped_ff     <= stopped_in;
      sqx_ff         <= sqx_in;
      sqy_ff         <= sqy_in;
      d2_ff          <= d2_in;
      rsp_stopped_ff <= rsp_stopped_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_d2_ff      <= rsp_d2_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_stopped          = rsp_stopped_ff;
   assign rsp_stop_x           = rsp_x_ff;
   assign rsp_stop_y           = rsp_y_ff;
   assign rsp_distance_squared = rsp_d2_ff;

   // read data is only tested the cycle after its address was issued
   `OGRC_ASSERT_NEXT(a_check_follows_issue, clock, reset, state_ff == ST_ISSUE, state_ff == ST_CHECK, "cell test did not follow its read")
   // map is only written by the clearing pass or an accepted write transaction
   `OGRC_ASSERT_SAME(a_ram_write_legal, clock, reset, ram_we, (state_ff == ST_CLEAR) || (req_accept && req_command == CMD_WRITE), "map written outside clear or write")
   // Bresenham error term stays in its half-open band while walking
   `OGRC_ASSERT_SAME(a_err_band, clock, reset, (state_ff == ST_ISSUE) && (da_ff != '0), (err_dbl < da_s) && (err_dbl >= -da_s), "error term out of range")

endmodule

`default_nettype wire

>>> rtl/core/ogrc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ogrc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
